FILE: rtl/modular_inverse_macros.svh
// Assertion macros shared by the modular inverse checkers.
// Needs signals named clk and arst_n in the scope of each use.
`ifndef MODULAR_INVERSE_MACROS_SVH
`define MODULAR_INVERSE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MINV_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("modular_inverse: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define MINV_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("modular_inverse: next-cycle check failed");

`endif

FILE: rtl/minv_pkg.sv
// Package for the modular inverse block: widths, sequencer state and control structs.
// No dependencies.
`timescale 1ns / 1ps

package minv_pkg;

	localparam int MOD_W = 31;
	localparam int VAL_W = 32;
	localparam int CNT_W = 5;
	localparam int COF_W = 34;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_ALIGN = 7'b0000010,
		ST_DIV   = 7'b0000100,
		ST_STEP  = 7'b0001000,
		ST_CHECK = 7'b0010000,
		ST_FOLD  = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	typedef struct packed {
		logic load;
		logic align;
		logic div;
		logic step;
		logic next;
		logic fold;
	} dp_ctrl_t;

	typedef struct packed {
		logic mod_zero;
		logic can_shift;
		logic last_bit;
		logic rem_small;
	} dp_stat_t;

endpackage

FILE: rtl/minv_datapath.sv
// Datapath of the modular inverse: one shift-subtract divider unit with cofactor
// accumulation, the remainder/cofactor pair and the final fold. Uses minv_pkg.
`timescale 1ns / 1ps

module minv_datapath
	import minv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [VAL_W-1:0] value,
	input  logic [MOD_W-1:0] modulus,
	input  dp_ctrl_t         ctrl,
	output dp_stat_t         stat,
	output logic [MOD_W-1:0] inverse
);

	logic [VAL_W-1:0]        num_q;
	logic [VAL_W-1:0]        den_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    first_q;
	logic signed [COF_W-1:0] prod_q;
	logic signed [COF_W-1:0] c0_q;
	logic signed [COF_W-1:0] c1_q;
	logic [MOD_W-1:0]        r0_q;
	logic [MOD_W-1:0]        r1_q;
	logic [MOD_W-1:0]        m_q;
	logic [MOD_W-1:0]        res_q;

	logic [VAL_W-1:0]        den_dbl;
	logic                    ge;
	logic [VAL_W-1:0]        diff;
	logic signed [COF_W-1:0] m_ext;
	logic signed [COF_W-1:0] fold_val;

	// Divider compare and subtract
	assign den_dbl = {den_q[VAL_W-2:0], 1'b0};
	assign ge      = (num_q >= den_q);
	assign diff    = num_q - den_q;

	// Fold the cofactor into [0, modulus)
	assign m_ext = $signed({{(COF_W-MOD_W){1'b0}}, m_q});
	always_comb begin
		if (c1_q[COF_W-1]) begin
			fold_val = c1_q + m_ext;
		end else if (c1_q >= m_ext) begin
			fold_val = c1_q - m_ext;
		end else begin
			fold_val = c1_q;
		end
	end

	// Status toward the sequencer
	assign stat.mod_zero  = (modulus == '0);
	assign stat.can_shift = !den_q[VAL_W-1] && (den_dbl <= num_q);
	assign stat.last_bit  = (cnt_q == '0);
	assign stat.rem_small = (r1_q <= MOD_W'(1));

	assign inverse = res_q;

	// Hold shift count and first-division flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			first_q <= 1'b0;
		end else begin
			if (ctrl.load || ctrl.next) begin
				cnt_q <= '0;
			end else if (ctrl.align && stat.can_shift) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (ctrl.div && !stat.last_bit) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (ctrl.load) begin
				first_q <= 1'b1;
			end else if (ctrl.step) begin
				first_q <= 1'b0;
			end
		end
	end

	// Advance divider, remainders and cofactors
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			num_q  <= value;
			den_q  <= {1'b0, modulus};
			prod_q <= '0;
			c0_q   <= '0;
			c1_q   <= COF_W'(1);
			m_q    <= modulus;
			res_q  <= '0;
		end else if (ctrl.align) begin
			if (stat.can_shift) begin
				den_q <= den_dbl;
			end
		end else if (ctrl.div) begin
			if (ge) begin
				num_q  <= diff;
				prod_q <= (prod_q <<< 1) + c1_q;
			end else begin
				prod_q <= prod_q <<< 1;
			end
			den_q <= den_q >> 1;
		end else if (ctrl.step) begin
			r1_q <= num_q[MOD_W-1:0];
			if (first_q) begin
				r0_q <= m_q;
			end else begin
				r0_q <= r1_q;
				c0_q <= c1_q;
				c1_q <= c0_q - prod_q;
			end
		end else if (ctrl.next) begin
			num_q  <= {1'b0, r0_q};
			den_q  <= {1'b0, r1_q};
			prod_q <= '0;
		end else if (ctrl.fold) begin
			res_q <= fold_val[MOD_W-1:0];
		end
	end

endmodule

FILE: rtl/minv_ctrl.sv
// Sequencer of the modular inverse: walks the shared divider through align,
// divide, update, check and fold steps. Uses minv_pkg.
`timescale 1ns / 1ps

module minv_ctrl
	import minv_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output dp_ctrl_t ctrl,
	output logic     busy,
	output logic     done
);

	state_t state_q;
	state_t state_d;

	// Decode next state and datapath controls
	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctrl.load = 1'b1;
					state_d   = stat.mod_zero ? ST_DONE : ST_ALIGN;
				end
			end
			ST_ALIGN: begin
				ctrl.align = 1'b1;
				if (!stat.can_shift) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				ctrl.div = 1'b1;
				if (stat.last_bit) begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				ctrl.step = 1'b1;
				state_d   = ST_CHECK;
			end
			ST_CHECK: begin
				if (stat.rem_small) begin
					state_d = ST_FOLD;
				end else begin
					ctrl.next = 1'b1;
					state_d   = ST_ALIGN;
				end
			end
			ST_FOLD: begin
				ctrl.fold = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

FILE: rtl/modular_inverse.sv
// Top level of the modular inverse block: sequencer plus divider datapath.
// Depends on minv_pkg, minv_ctrl and minv_datapath.
`timescale 1ns / 1ps

// Usage:
//   Drive value and modulus and raise start while busy is low; the request is
//   taken on that clock edge and busy rises in the next cycle. The block works
//   on one request at a time.
//   The result appears on inverse, marked by done for exactly one cycle; the
//   receiver must take it then, it cannot stall the block.
// Sequence:
//   The request is loaded, the first division reduces value by modulus, then
//   each extended Euclid step runs one division on the shared shift-subtract
//   unit. A division shifts the divisor up while its double stays at or below
//   the dividend, makes one exit check, runs one subtract step per quotient
//   bit, then updates remainders and cofactors and checks the remainder.
//   After the last division the cofactor is folded and done is shown. The
//   run time grows with the sum of quotient bit lengths.
//   A zero modulus shows 0 with done in the cycle right after the request.
// Reset:
//   arst_n clears the sequencer to idle; no result is pending after reset.

module modular_inverse
	import minv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [VAL_W-1:0] value,
	input  logic [MOD_W-1:0] modulus,
	output logic             done,
	output logic [MOD_W-1:0] inverse
);

	dp_ctrl_t ctrl;
	dp_stat_t stat;

	// Sequence the shared divider
	minv_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy),
		.done   (done)
	);

	// Hold remainders, cofactors and the result
	minv_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.value   (value),
		.modulus (modulus),
		.ctrl    (ctrl),
		.stat    (stat),
		.inverse (inverse)
	);

endmodule

FILE: rtl/minv_checker.sv
// Port-level checker for the modular inverse block, bound to the top level.
// Depends on modular_inverse_macros.svh and minv_pkg.
`timescale 1ns / 1ps
`include "modular_inverse_macros.svh"

module minv_checker
	import minv_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic [VAL_W-1:0] value,
	input logic [MOD_W-1:0] modulus,
	input logic             done,
	input logic [MOD_W-1:0] inverse
);

	// A result only shows while a request is in flight
	`MINV_ASSERT_IMPL(a_done_busy, done, busy)
	// An accepted request keeps the block busy
	`MINV_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	// A result ends the request and is shown once
	`MINV_ASSERT_NEXT(a_done_idle, done, !busy && !done)
	// A zero modulus answers 0 at once
	`MINV_ASSERT_NEXT(a_zero_mod, start && !busy && modulus == '0 && value == value,
		done && inverse == '0)

endmodule

bind modular_inverse minv_checker u_chk (.*);
